### rtl/tmblt_pkg.sv
// ----------------------------------------------------------------------------
// tmblt_pkg
// Shared types and constants of the two-mode bucket lock table.
// ----------------------------------------------------------------------------
package tmblt_pkg;

  localparam int unsigned Sets      = 1024;
  localparam int unsigned Ways      = 4;
  localparam int unsigned CountBits = 32;
  localparam int unsigned SetBits   = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned WayBits   = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned RowBits   = Ways * (64 + CountBits);

  // command codes
  localparam logic [1:0] CmdLock    = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdQuery   = 2'd2;

  // result reason codes
  localparam logic [2:0] RsnOk        = 3'd0;
  localparam logic [2:0] RsnOtherMode = 3'd1;
  localparam logic [2:0] RsnSetFull   = 3'd2;
  localparam logic [2:0] RsnLimit     = 3'd3;
  localparam logic [2:0] RsnNotFound  = 3'd4;
  localparam logic [2:0] RsnMismatch  = 3'd5;

  typedef logic signed [CountBits-1:0] count_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key;
    logic [SetBits-1:0] set;
    logic               mode;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] reason;
    logic       wake;
  } rsp_t;

endpackage

### rtl/tmblt_if.sv
// ----------------------------------------------------------------------------
// tmblt_req_if / tmblt_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface tmblt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] key;
  logic [9:0]  set_index;
  logic        mode;
  modport source (output valid, cmd, key, set_index, mode, input ready);
  modport sink   (input valid, cmd, key, set_index, mode, output ready);
endinterface

interface tmblt_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic [2:0] reason;
  logic       wake;
  modport source (output valid, granted, reason, wake, input ready);
  modport sink   (input valid, granted, reason, wake, output ready);
endinterface

### rtl/two_mode_bucket_lock_table.sv
// ----------------------------------------------------------------------------
// two_mode_bucket_lock_table
// Set-associative lock table with update and copy holder counts.
// ----------------------------------------------------------------------------
// the queue pop and set read happen in StIdle, the decision and write-back in
// StRead, and the response is held valid in StOut until taken; a new request is
// not popped before then. A 2-entry queue accepts requests meanwhile.
// after reset a clearing pass zeroes every set of the table; requests queue
// but are not processed until it ends
module two_mode_bucket_lock_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmblt_req_if.sink   req,
  tmblt_rsp_if.source rsp
);
  import tmblt_pkg::*;

  req_t fifo_data;
  logic fifo_valid, fifo_pop;

  tmblt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .fifo_data_o (fifo_data),
    .fifo_valid_o(fifo_valid),
    .fifo_pop_i  (fifo_pop)
  );

  tmblt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_data_i (fifo_data),
    .fifo_valid_i(fifo_valid),
    .fifo_pop_o  (fifo_pop),
    .rsp         (rsp)
  );

endmodule

### rtl/tmblt_ram.sv
// ----------------------------------------------------------------------------
// tmblt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tmblt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/tmblt_front.sv
// ----------------------------------------------------------------------------
// tmblt_front
// Accepts request words, folds the set index and queues them for the back end.
// ----------------------------------------------------------------------------
module tmblt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  tmblt_req_if.sink       req,
  output tmblt_pkg::req_t fifo_data_o,
  output logic            fifo_valid_o,
  input  logic            fifo_pop_i
);
  import tmblt_pkg::*;

  localparam int unsigned Depth = 2;

  req_t               ent_q [Depth];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               push;
  req_t               in_w;
  logic [SetBits-1:0] folded;

  // set index modulo table size
  assign folded = SetBits'(req.set_index % Sets);

  always_comb begin
    in_w.cmd  = req.cmd;
    in_w.key  = req.key;
    in_w.set  = folded;
    in_w.mode = req.mode;
  end

  assign req.ready    = (cnt_q != 2'd2);
  assign push         = req.valid && req.ready;
  assign fifo_valid_o = (cnt_q != 2'd0);
  assign fifo_data_o  = ent_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= in_w;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (fifo_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(fifo_pop_i);
    end
  end

endmodule

### rtl/tmblt_back.sv
// ----------------------------------------------------------------------------
// tmblt_back
// Reads one set, decides the command and writes the set back.
// A clearing pass sweeps the table after reset.
// ----------------------------------------------------------------------------
module tmblt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tmblt_pkg::req_t fifo_data_i,
  input  logic            fifo_valid_i,
  output logic            fifo_pop_o,
  tmblt_rsp_if.source     rsp
);
  import tmblt_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StRead  = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  localparam count_t CntMax = {1'b0, {(CountBits-1){1'b1}}};
  localparam count_t CntMin = {1'b1, {(CountBits-1){1'b0}}};

  logic [1:0]         state_q, state_d;
  logic [SetBits-1:0] clr_q;
  req_t               cur_q;
  rsp_t               rsp_q, rsp_d;
  logic               we;
  logic [SetBits-1:0] waddr;
  logic [RowBits-1:0] wdata, rdata, row_new;

  tmblt_ram #(.Width(RowBits), .Depth(Sets)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(fifo_data_i.set),
    .rdata_o(rdata)
  );

  // way unpacking and decision
  logic [63:0]        wk [Ways];
  count_t             wc [Ways];
  logic [Ways-1:0]    hit, free;
  logic               any_hit, any_free;
  logic [WayBits-1:0] hit_w, free_w, sel_w;
  count_t             v, v_new;
  logic               wr_row;

  always_comb begin
    for (int i = 0; i < Ways; i++) begin
      wk[i]   = rdata[i*(64+CountBits) +: 64];
      wc[i]   = rdata[i*(64+CountBits)+64 +: CountBits];
      hit[i]  = (wk[i] == cur_q.key);
      free[i] = (wc[i] == '0);
    end
    any_hit = |hit;
    any_free = |free;
    hit_w = '0;
    free_w = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      if (hit[i]) hit_w = WayBits'(i);
      if (free[i]) free_w = WayBits'(i);
    end
    sel_w = any_hit ? hit_w : free_w;
    v = wc[sel_w];
    v_new = v;
    wr_row = 1'b0;
    rsp_d = '0;
    unique case (cur_q.cmd)
      CmdLock: begin
        if (any_hit && (cur_q.mode ? v < 0 : v > 0)) begin
          rsp_d.reason = RsnOtherMode;
        end else if (!any_hit && !any_free) begin
          rsp_d.reason = RsnSetFull;
        end else begin
          // the selected way is written back even when the limit check fails
          wr_row = 1'b1;
          if (cur_q.mode ? v == CntMax : v == CntMin) begin
            rsp_d.reason = RsnLimit;
          end else begin
            v_new = cur_q.mode ? v + count_t'(1) : v - count_t'(1);
            rsp_d.granted = 1'b1;
          end
        end
      end
      CmdRelease: begin
        if (!any_hit) begin
          rsp_d.reason = RsnNotFound;
        end else if (cur_q.mode ? v <= 0 : v >= 0) begin
          rsp_d.reason = RsnMismatch;
        end else begin
          v_new = cur_q.mode ? v - count_t'(1) : v + count_t'(1);
          wr_row = 1'b1;
          rsp_d.granted = 1'b1;
          rsp_d.wake = (v_new == '0);
        end
      end
      CmdQuery: begin
        for (int i = 0; i < Ways; i++) begin
          if (hit[i] && !free[i]) rsp_d.granted = 1'b1;
        end
      end
      default: ;
    endcase
    row_new = rdata;
    row_new[sel_w*(64+CountBits) +: 64]           = cur_q.key;
    row_new[sel_w*(64+CountBits)+64 +: CountBits] = v_new;
  end

  // write port: clearing pass or write-back
  always_comb begin
    if (state_q == StClear) begin
      we = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we = (state_q == StRead) && wr_row;
      waddr = cur_q.set;
      wdata = row_new;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    fifo_pop_o = 1'b0;
    unique case (state_q)
      StClear: if (clr_q == SetBits'(Sets - 1)) state_d = StIdle;
      StIdle: begin
        if (fifo_valid_i) begin
          fifo_pop_o = 1'b1;
          state_d = StRead;
        end
      end
      StRead: state_d = StOut;
      StOut: if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) cur_q <= fifo_data_i;
    if (state_q == StRead) rsp_q <= rsp_d;
  end

  assign rsp.valid   = (state_q == StOut);
  assign rsp.granted = rsp_q.granted;
  assign rsp.reason  = rsp_q.reason;
  assign rsp.wake    = rsp_q.wake;

endmodule

### rtl/tmblt_checker.sv
// ----------------------------------------------------------------------------
// tmblt_checker
// Port-level checks of the lock table response channel.
// ----------------------------------------------------------------------------
module tmblt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_granted_i,
  input logic [2:0] rsp_reason_i,
  input logic       rsp_wake_i
);
  import tmblt_pkg::*;

  // response held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_reason_i))
    else $error("response dropped while stalled");

  // granted only with reason ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_granted_i |-> rsp_reason_i == RsnOk)
    else $error("granted with error reason");

  // wake only on a granted response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_wake_i |-> rsp_granted_i)
    else $error("wake without grant");

  // reason in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_reason_i <= RsnMismatch)
    else $error("reason out of range");

endmodule

bind two_mode_bucket_lock_table tmblt_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_granted_i(rsp.granted),
  .rsp_reason_i (rsp.reason),
  .rsp_wake_i   (rsp.wake)
);

### verif/two_mode_bucket_lock_table_test.sv
// ----------------------------------------------------------------------------
// two_mode_bucket_lock_table_test
// Drives lock, release, query and unused words into the table, predicts each
// response from a local copy of the table and checks every response word.
// ----------------------------------------------------------------------------
module two_mode_bucket_lock_table_test;
  import tmblt_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [9:0]  set_index;
    logic        mode;
  } lock_req_t;

  logic clk_i;
  logic rst_ni;

  tmblt_req_if req ();
  tmblt_rsp_if rsp ();

  two_mode_bucket_lock_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  // local copy of the table
  logic [63:0] table_keys [Sets*Ways];
  count_t      table_counts [Sets*Ways];

  lock_req_t pending_reqs [$];
  rsp_t      expected_rsps [$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned rsp_count;
  int unsigned grant_count;
  int unsigned wake_count;
  bit          stim_done;
  bit          quiet_phase;
  int unsigned hold_off;
  int unsigned send_gap;
  int unsigned recv_gap;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // predict one response and update the local table
  function automatic rsp_t predict_lock(lock_req_t r);
    rsp_t        o;
    int          base;
    int          w;
    int          hit;
    int          idx;
    count_t      v;
    count_t      cmax;
    count_t      cmin;
    o = '0;
    base = (r.set_index % Sets) * Ways;
    cmax = {1'b0, {(CountBits-1){1'b1}}};
    cmin = {1'b1, {(CountBits-1){1'b0}}};
    hit = -1;
    for (w = Ways - 1; w >= 0; w--)
      if (table_keys[base+w] == r.key) hit = w;
    case (r.cmd)
      CmdLock: begin
        if (hit >= 0) begin
          v = table_counts[base+hit];
          if (r.mode ? (v < 0) : (v > 0)) begin
            o.reason = RsnOtherMode;
            return o;
          end
        end else begin
          for (w = Ways - 1; w >= 0; w--)
            if (table_counts[base+w] == 0) hit = w;
          if (hit < 0) begin
            o.reason = RsnSetFull;
            return o;
          end
          table_keys[base+hit] = r.key;
        end
        idx = base + hit;
        v = table_counts[idx];
        if (r.mode ? (v == cmax) : (v == cmin)) begin
          o.reason = RsnLimit;
          return o;
        end
        table_counts[idx] = r.mode ? v + 1 : v - 1;
        o.granted = 1'b1;
      end
      CmdRelease: begin
        if (hit < 0) begin
          o.reason = RsnNotFound;
          return o;
        end
        idx = base + hit;
        v = table_counts[idx];
        if (r.mode ? (v <= 0) : (v >= 0)) begin
          o.reason = RsnMismatch;
          return o;
        end
        v = r.mode ? v - 1 : v + 1;
        table_counts[idx] = v;
        o.granted = 1'b1;
        o.wake = (v == 0);
      end
      CmdQuery: begin
        for (w = 0; w < Ways; w++)
          if (table_keys[base+w] == r.key && table_counts[base+w] != 0) o.granted = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic lock_req_t make_req(logic [1:0] c, logic [63:0] k, logic [9:0] s,
                                         logic m);
    lock_req_t r;
    r.cmd = c;
    r.key = k;
    r.set_index = s;
    r.mode = m;
    return r;
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // stimulus
  initial begin
    lock_req_t   r;
    logic [63:0] k;
    logic [63:0] pool [8];
    logic [9:0]  s;
    int          i;
    int          j;
    int          n;
    k = 64'hFFFF_FFFF_FFFF_FFFF;
    // directed: extremes, every command, each refusal and error but the limit
    pending_reqs.push_back(make_req(CmdQuery, 64'd0, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdRelease, k, 10'd1023, 1'b1));
    pending_reqs.push_back(make_req(CmdLock, k, 10'd1023, 1'b1));
    pending_reqs.push_back(make_req(CmdLock, k, 10'd1023, 1'b0));
    pending_reqs.push_back(make_req(CmdRelease, k, 10'd1023, 1'b0));
    pending_reqs.push_back(make_req(CmdQuery, k, 10'd1023, 1'b1));
    pending_reqs.push_back(make_req(CmdRelease, k, 10'd1023, 1'b1));
    pending_reqs.push_back(make_req(CmdLock, 64'd0, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdLock, 64'd0, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdLock, 64'd0, 10'd0, 1'b1));
    for (i = 1; i <= 4; i++)
      pending_reqs.push_back(make_req(CmdLock, 64'(i), 10'd0, 1'b1));
    pending_reqs.push_back(make_req(CmdUnused, k, 10'h2AA, 1'b1));
    pending_reqs.push_back(make_req(CmdRelease, 64'd0, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdRelease, 64'd0, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdLock, 64'd9, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdQuery, 64'd0, 10'd0, 1'b0));
    pending_reqs.push_back(make_req(CmdQuery, 64'h5555_AAAA_5555_AAAA, 10'h155, 1'b0));

    // random: a small key pool over few sets keeps sets busy and full
    for (i = 0; i < 880; i++) begin
      if (i % 110 == 0)
        for (j = 0; j < 8; j++) pool[j] = ($urandom_range(3) == 0) ? rand_key() : 64'(j);
      s = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(3) * 341);
      n = $urandom_range(99);
      if (n < 90) begin
        k = pool[$urandom_range(7)];
        r = make_req(n < 45 ? CmdLock : (n < 80 ? CmdRelease : CmdQuery), k, s,
                     1'($urandom_range(1)));
      end else begin
        r = make_req(2'($urandom), rand_key(), 10'($urandom), 1'($urandom));
      end
      pending_reqs.push_back(r);
    end
    stim_done = 1'b1;
  end

  // driver
  initial begin
    int i;
    req.valid = 1'b0;
    req.cmd = '0;
    req.key = '0;
    req.set_index = '0;
    req.mode = 1'b0;
    rsp.ready = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_off = 0;
    mismatches = 0;
    cycles = 0;
    rsp_count = 0;
    grant_count = 0;
    wake_count = 0;
    for (i = 0; i < Sets * Ways; i++) begin
      table_keys[i] = '0;
      table_counts[i] = '0;
    end
  end

  always @(posedge clk_i) quiet_phase <= (pending_reqs.size() < 150);

  always @(posedge clk_i) begin
    lock_req_t r;
    if (rst_ni) begin
      if (req.valid && req.ready)
        expected_rsps.push_back(predict_lock(make_req(req.cmd, req.key, req.set_index,
                                                      req.mode)));
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !quiet_phase && $urandom_range(9) == 0) begin
          send_gap <= $urandom_range(5);
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.cmd <= r.cmd;
          req.key <= r.key;
          req.set_index <= r.set_index;
          req.mode <= r.mode;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, with one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_count == 300 && hold_off == 0) begin
        hold_off <= 1;
        rsp.ready <= 1'b0;
      end else if (hold_off > 0 && hold_off < 60) begin
        hold_off <= hold_off + 1;
        rsp.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(7) == 0) begin
        recv_gap <= $urandom_range(5);
        rsp.ready <= 1'b0;
      end else begin
        if (hold_off == 60) hold_off <= 61;
        rsp.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      rsp_count <= rsp_count + 1;
      if (expected_rsps.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected response word at cycle %0d", cycles);
      end else begin
        e = expected_rsps.pop_front();
        grant_count <= grant_count + e.granted;
        wake_count <= wake_count + e.wake;
        if (rsp.granted !== e.granted || rsp.reason !== e.reason || rsp.wake !== e.wake) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch at cycle %0d: expected granted %0d reason %0d wake %0d,",
                      " got %0d %0d %0d"},
                     cycles, e.granted, e.reason, e.wake, rsp.granted, rsp.reason, rsp.wake);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout with %0d responses outstanding", expected_rsps.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d response words checked, %0d granted, %0d wakes", rsp_count, grant_count,
             wake_count);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### two_mode_bucket_lock_table.f
rtl/tmblt_pkg.sv
rtl/tmblt_if.sv
rtl/tmblt_ram.sv
rtl/tmblt_front.sv
rtl/tmblt_back.sv
rtl/two_mode_bucket_lock_table.sv
rtl/tmblt_checker.sv
verif/two_mode_bucket_lock_table_test.sv
